// ===== rtl/core/mexp_pkg.sv =====
// Shared constants, types and control structs for the modular exponentiation unit.
`default_nettype none

package mexp_pkg;

	// Field widths
	localparam int BASE_W = 64;
	localparam int EXP_W  = 63;
	localparam int RES_W  = 30;

	// Default number of exponent bits walked by the square-and-multiply loop
	localparam int EXP_BITS_DEF = 63;

	// Modulus and the exponent used for the Fermat inverse
	localparam logic [RES_W-1:0] PRIME   = 30'd998244353;
	localparam logic [RES_W-1:0] INV_EXP = 30'(32'd998244353 - 32'd2);

	// Base reduction: one digit of RED_DIGIT bits per cycle, MSB first
	localparam int RED_DIGIT = 4;
	localparam int RED_STEPS = BASE_W / RED_DIGIT;

	// Barrett reduction: product < 2^60, estimate uses product[59:29] * M >> 31
	localparam int BAR_K     = 60;
	localparam int BAR_SHIFT = 29;
	localparam int BAR_W     = BAR_K - BAR_SHIFT;
	localparam logic [BAR_W-1:0] BARRETT_M =
		BAR_W'((64'd1 << BAR_K) / 64'(PRIME));

	// Controller -> datapath commands
	typedef struct packed {
		logic load;         // take a new item
		logic red_step;     // one digit of base reduction
		logic fix;          // sign fixup of base, acc <= 1
		logic mm_start;     // launch a modular multiply
		logic mm_sel_base;  // 0: acc*acc, 1: acc*base
		logic acc_wr;       // acc <= multiplier result
		logic e_shift;      // advance to next exponent bit
		logic out_load;     // result register <= acc
	} cmd_t;

	// Datapath -> controller status
	typedef struct packed {
		logic mm_done;
		logic e_msb;
	} sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/mexp_if.sv =====
// Valid/ready channel interfaces for operand items and result items.
`default_nettype none

interface mexp_in_if;
	logic                                valid;
	logic                                ready;
	logic                                mode;
	logic signed [mexp_pkg::BASE_W-1:0]  base;
	logic        [mexp_pkg::EXP_W-1:0]   exponent;

	modport source (output valid, output mode, output base, output exponent, input ready);
	modport sink   (input valid, input mode, input base, input exponent, output ready);
endinterface

interface mexp_out_if;
	logic                        valid;
	logic                        ready;
	logic [mexp_pkg::RES_W-1:0]  result;

	modport source (output valid, output result, input ready);
	modport sink   (input valid, input result, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/mexp_mulmod.sv =====
// Four-stage Barrett modular multiplier, a*b mod p for operands below p.
`default_nettype none

module mexp_mulmod (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [mexp_pkg::RES_W-1:0]  a,
	input  wire logic [mexp_pkg::RES_W-1:0]  b,
	output logic                             done,
	output logic      [mexp_pkg::RES_W-1:0]  r
);

	localparam int PW = 2 * mexp_pkg::RES_W;
	localparam int QW = mexp_pkg::BAR_W;
	localparam int TW = mexp_pkg::RES_W + 2;  // holds up to 3p

	logic [PW-1:0]         x_s1;
	logic [QW-1:0]         q_s2;
	logic [TW-1:0]         lo_s2;
	logic [TW-1:0]         t_s3;
	logic [mexp_pkg::RES_W-1:0] r_s4;
	logic                  v_s1, v_s2, v_s3, v_s4;

	logic [2*QW-1:0]       qest;
	logic [QW+mexp_pkg::RES_W-1:0] qp;
	logic [TW-1:0]         p1, p2;
	logic [TW-1:0]         t_fix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// S1: raw product
	always_ff @(posedge clk) begin
		x_s1 <= PW'(a) * PW'(b);
	end

	// S2: quotient estimate, at most two short of the true quotient
	assign qest = (2*QW)'(x_s1[PW-1:mexp_pkg::BAR_SHIFT]) * (2*QW)'(mexp_pkg::BARRETT_M);

	always_ff @(posedge clk) begin
		q_s2  <= qest[2*QW-1:QW];
		lo_s2 <= x_s1[TW-1:0];
	end

	// S3: remainder estimate, below 3p so the low bits suffice
	assign qp = (QW+mexp_pkg::RES_W)'(q_s2) * (QW+mexp_pkg::RES_W)'(mexp_pkg::PRIME);

	always_ff @(posedge clk) begin
		t_s3 <= lo_s2 - qp[TW-1:0];
	end

	// S4: final correction
	assign p1 = TW'(mexp_pkg::PRIME);
	assign p2 = p1 << 1;

	always_comb begin
		if (t_s3 >= p2) begin
			t_fix = t_s3 - p2;
		end else if (t_s3 >= p1) begin
			t_fix = t_s3 - p1;
		end else begin
			t_fix = t_s3;
		end
	end

	always_ff @(posedge clk) begin
		r_s4 <= t_fix[mexp_pkg::RES_W-1:0];
	end

	assign done = v_s4;
	assign r    = r_s4;

endmodule

`default_nettype wire

// ===== rtl/core/mexp_dp.sv =====
// Datapath: base reduction, exponent shifter, accumulator and result register.
`default_nettype none

module mexp_dp #(
	parameter int EXP_BITS = mexp_pkg::EXP_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire mexp_pkg::cmd_t                      cmd,
	output mexp_pkg::sts_t                           sts,
	input  wire logic                                mode,
	input  wire logic signed [mexp_pkg::BASE_W-1:0]  base,
	input  wire logic        [mexp_pkg::EXP_W-1:0]   exponent,
	output logic             [mexp_pkg::RES_W-1:0]   result
);

	localparam int BW = mexp_pkg::BASE_W;
	localparam int RW = mexp_pkg::RES_W;
	localparam int DG = mexp_pkg::RED_DIGIT;

	logic [BW-1:0]       mag_q;
	logic                neg_q;
	logic [RW-1:0]       r_q;
	logic [RW-1:0]       b_q;
	logic [RW-1:0]       acc_q;
	logic [EXP_BITS-1:0] e_q;
	logic [RW-1:0]       res_q;

	logic [RW:0]         red_v [DG+1];
	logic [RW-1:0]       red_next;
	logic [RW-1:0]       b_fixed;
	logic [RW-1:0]       mm_b;
	logic [RW-1:0]       mm_r;
	logic                mm_done;

	// Shift-and-subtract reduction, one digit per cycle
	always_comb begin
		red_v[0] = {1'b0, r_q};
		for (int i = 0; i < DG; i++) begin
			red_v[i+1] = {red_v[i][RW-1:0], mag_q[BW-1-i]};
			if (red_v[i+1] >= (RW+1)'(mexp_pkg::PRIME)) begin
				red_v[i+1] = red_v[i+1] - (RW+1)'(mexp_pkg::PRIME);
			end
		end
		red_next = red_v[DG][RW-1:0];
	end

	// Negative base wraps to p - r unless r is zero
	assign b_fixed = (neg_q && (r_q != '0)) ? (mexp_pkg::PRIME - r_q) : r_q;

	assign mm_b = cmd.mm_sel_base ? b_q : acc_q;

	mexp_mulmod u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mm_start),
		.a      (acc_q),
		.b      (mm_b),
		.done   (mm_done),
		.r      (mm_r)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q <= base[BW-1];
			mag_q <= base[BW-1] ? (~base + BW'(1)) : base;
			r_q   <= '0;
			e_q   <= mode ? EXP_BITS'(mexp_pkg::INV_EXP) : exponent[EXP_BITS-1:0];
		end else begin
			if (cmd.red_step) begin
				mag_q <= mag_q << DG;
				r_q   <= red_next;
			end
			if (cmd.e_shift) begin
				e_q <= e_q << 1;
			end
		end
		if (cmd.fix) begin
			b_q   <= b_fixed;
			acc_q <= RW'(1);
		end else if (cmd.acc_wr) begin
			acc_q <= mm_r;
		end
		if (cmd.out_load) begin
			res_q <= acc_q;
		end
	end

	assign sts.mm_done = mm_done;
	assign sts.e_msb   = e_q[EXP_BITS-1];
	assign result      = res_q;

endmodule

`default_nettype wire

// ===== rtl/core/mexp_ctrl.sv =====
// Controller: sequences reduction, square-and-multiply steps and result hand-off.
`default_nettype none

module mexp_ctrl #(
	parameter int EXP_BITS = mexp_pkg::EXP_BITS_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire logic            out_ready,
	input  wire mexp_pkg::sts_t  sts,
	output mexp_pkg::cmd_t       cmd
);

	localparam int RCW = $clog2(mexp_pkg::RED_STEPS);
	localparam int BCW = $clog2(EXP_BITS);

	typedef enum logic [8:0] {
		ST_IDLE     = 9'b000000001,
		ST_RED      = 9'b000000010,
		ST_FIX      = 9'b000000100,
		ST_SQ_GO    = 9'b000001000,
		ST_SQ_WAIT  = 9'b000010000,
		ST_MUL_GO   = 9'b000100000,
		ST_MUL_WAIT = 9'b001000000,
		ST_NEXT     = 9'b010000000,
		ST_DONE     = 9'b100000000
	} state_t;

	state_t         state_q, state_nx;
	logic [RCW-1:0] red_cnt_q;
	logic [BCW-1:0] bit_cnt_q;
	logic           out_valid_q;
	logic           accept;
	logic           out_free;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = ST_RED;
				end
			end
			ST_RED: begin
				cmd.red_step = 1'b1;
				if (red_cnt_q == RCW'(mexp_pkg::RED_STEPS - 1)) begin
					state_nx = ST_FIX;
				end
			end
			ST_FIX: begin
				cmd.fix  = 1'b1;
				state_nx = ST_SQ_GO;
			end
			ST_SQ_GO: begin
				cmd.mm_start = 1'b1;
				state_nx     = ST_SQ_WAIT;
			end
			ST_SQ_WAIT: begin
				if (sts.mm_done) begin
					cmd.acc_wr = 1'b1;
					state_nx   = sts.e_msb ? ST_MUL_GO : ST_NEXT;
				end
			end
			ST_MUL_GO: begin
				cmd.mm_start    = 1'b1;
				cmd.mm_sel_base = 1'b1;
				state_nx        = ST_MUL_WAIT;
			end
			ST_MUL_WAIT: begin
				if (sts.mm_done) begin
					cmd.acc_wr = 1'b1;
					state_nx   = ST_NEXT;
				end
			end
			ST_NEXT: begin
				cmd.e_shift = 1'b1;
				state_nx    = (bit_cnt_q == BCW'(EXP_BITS - 1)) ? ST_DONE : ST_SQ_GO;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_nx     = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			red_cnt_q   <= '0;
			bit_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (accept) begin
				red_cnt_q <= '0;
			end else if (state_q == ST_RED) begin
				red_cnt_q <= red_cnt_q + RCW'(1);
			end
			if (state_q == ST_FIX) begin
				bit_cnt_q <= '0;
			end else if (state_q == ST_NEXT) begin
				bit_cnt_q <= bit_cnt_q + BCW'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/core/modular_exponentiation_unit_top.sv =====
// One item at a time: the next item is taken once the result is registered, which waits
// while an earlier result is still held unaccepted on the output.
// The multiplier pipeline is occupied by each square and each multiply in turn.
// Reset (arst_n low, asynchronous) returns the controller to idle and drops the result valid.
`default_nettype none

module modular_exponentiation_unit_top #(
	parameter int EXP_BITS = mexp_pkg::EXP_BITS_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	mexp_in_if.sink     operand,
	mexp_out_if.source  answer
);

	// Command and status between the sequencer and the arithmetic
	mexp_pkg::cmd_t cmd;
	mexp_pkg::sts_t sts;

	// Controller: owns the handshakes, step counters and the result valid flag.
	// The result register sits in the datapath, so a finished item can wait on
	// the output while the controller is back in idle taking the next one.
	mexp_ctrl #(
		.EXP_BITS (EXP_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (operand.valid),
		.in_ready  (operand.ready),
		.out_valid (answer.valid),
		.out_ready (answer.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath: base reduced MSB-first one digit per cycle, then left-to-right
	// square-and-multiply over the low EXP_BITS exponent bits (p-2 in inverse mode)
	mexp_dp #(
		.EXP_BITS (EXP_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.mode     (operand.mode),
		.base     (operand.base),
		.exponent (operand.exponent),
		.result   (answer.result)
	);

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for modular_exponentiation_unit_top: base^exponent and inverse mod prime.
`timescale 1ns / 1ps

module testbench;

	localparam int EXP_BITS      = mexp_pkg::EXP_BITS_DEF;
	localparam int WATCHDOG_MAX  = 6000;
	localparam int DRAIN_CYCLES  = 800;
	localparam int RANDOM_ITEMS  = 1130;
	localparam longint unsigned PRIME_U = longint'(mexp_pkg::PRIME);

	typedef struct {
		logic                               mode;
		logic signed [mexp_pkg::BASE_W-1:0] base;
		logic        [mexp_pkg::EXP_W-1:0]  exponent;
	} operand_item_t;

	logic clk = 1'b0;
	logic arst_n;

	mexp_in_if  operand ();
	mexp_out_if answer ();

	modular_exponentiation_unit_top #(
		.EXP_BITS(EXP_BITS)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.operand (operand),
		.answer  (answer)
	);

	// Items waiting to be offered, and results owed by the block in order.
	operand_item_t                pending_operands[$];
	logic [mexp_pkg::RES_W-1:0]   expected_results[$];

	int accepted_items = 0;
	int total_items    = 1;
	int mismatches     = 0;
	int stall_cycles   = 0;
	int send_idle_pct;
	int take_idle_pct;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Three traffic phases by progress through the stimulus:
	// sender mostly busy / receiver mostly stalled, then swapped, then no idling.
	always_comb begin
		if (accepted_items < total_items / 3) begin
			send_idle_pct = 9;
			take_idle_pct = 85;
		end else if (accepted_items < (2 * total_items) / 3) begin
			send_idle_pct = 85;
			take_idle_pct = 9;
		end else begin
			send_idle_pct = 0;
			take_idle_pct = 0;
		end
	end

	// Signed base to its residue in 0..p-1; negatives wrap up.
	function automatic longint unsigned base_residue(logic signed [mexp_pkg::BASE_W-1:0] raw);
		longint unsigned magnitude;
		longint unsigned rem;
		magnitude = raw[mexp_pkg::BASE_W-1] ? (~raw) + 64'd1 : raw;
		rem       = magnitude % PRIME_U;
		if (raw[mexp_pkg::BASE_W-1] && rem != 0)
			rem = PRIME_U - rem;
		return rem;
	endfunction

	// Left-to-right square-and-multiply over the low EXP_BITS exponent bits.
	function automatic logic [mexp_pkg::RES_W-1:0] power_mod(logic mode,
			logic signed [mexp_pkg::BASE_W-1:0] raw, logic [mexp_pkg::EXP_W-1:0] exponent);
		longint unsigned b;
		longint unsigned acc;
		logic [mexp_pkg::EXP_W-1:0] e;
		b   = base_residue(raw);
		acc = 1;
		e   = mode ? mexp_pkg::EXP_W'(mexp_pkg::INV_EXP) : exponent;
		for (int bit_idx = EXP_BITS - 1; bit_idx >= 0; bit_idx--) begin
			acc = (acc * acc) % PRIME_U;
			if (e[bit_idx])
				acc = (acc * b) % PRIME_U;
		end
		return mexp_pkg::RES_W'(acc);
	endfunction

	task automatic add_item(logic mode, logic signed [mexp_pkg::BASE_W-1:0] base,
			logic [mexp_pkg::EXP_W-1:0] exponent);
		operand_item_t it;
		it.mode     = mode;
		it.base     = base;
		it.exponent = exponent;
		pending_operands.push_back(it);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Random item; base and exponent each from a mix of shapes.
	function automatic operand_item_t random_operand();
		operand_item_t it;
		longint        k;
		it.mode = ($urandom_range(99) < 25);
		case ($urandom_range(5))
			0, 1: it.base = rand64();
			2: it.base = longint'($urandom_range(2000)) - 1000;
			3: begin
				// just around a multiple of p, either sign
				k = longint'($urandom_range(4000)) - 2000;
				it.base = k * longint'(PRIME_U) + longint'($urandom_range(4)) - 2;
			end
			4: it.base = longint'($urandom_range(PRIME_U - 1));
			default: it.base = $urandom_range(1) ? 64'sh7fff_ffff_ffff_ffff - $urandom_range(3)
				: 64'sh8000_0000_0000_0000 + $urandom_range(3);
		endcase
		case ($urandom_range(4))
			0, 1, 2: it.exponent = mexp_pkg::EXP_W'(rand64());
			3: it.exponent = mexp_pkg::EXP_W'($urandom_range(70));
			default: it.exponent = mexp_pkg::EXP_W'(1) << $urandom_range(mexp_pkg::EXP_W - 1);
		endcase
		return it;
	endfunction

	// Operand driver: offer the next item once the current one is taken.
	always @(posedge clk or negedge arst_n) begin
		operand_item_t nxt;
		if (!arst_n) begin
			operand.valid    <= 1'b0;
			operand.mode     <= 1'b0;
			operand.base     <= '0;
			operand.exponent <= '0;
		end else begin
			if (operand.valid && operand.ready) begin
				expected_results.push_back(power_mod(operand.mode, operand.base,
					operand.exponent));
				accepted_items <= accepted_items + 1;
			end
			if (!operand.valid || operand.ready) begin
				if (pending_operands.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = pending_operands.pop_front();
					operand.valid    <= 1'b1;
					operand.mode     <= nxt.mode;
					operand.base     <= nxt.base;
					operand.exponent <= nxt.exponent;
				end else begin
					operand.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: check each taken result against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		logic [mexp_pkg::RES_W-1:0] want;
		if (!arst_n) begin
			answer.ready <= 1'b0;
		end else begin
			if (answer.valid && answer.ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result with none expected: actual %0d", $time, answer.result);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					if (answer.result !== want) begin
						$display("%0t: result mismatch: expected %0d actual %0d",
							$time, want, answer.result);
						mismatches++;
					end
				end
			end
			answer.ready <= ($urandom_range(99) >= take_idle_pct);
		end
	end

	// Watchdog: too long with no item moving on either channel.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((operand.valid && operand.ready) || (answer.valid && answer.ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= WATCHDOG_MAX) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		arst_n           = 1'b0;
		operand.valid    = 1'b0;
		operand.mode     = 1'b0;
		operand.base     = '0;
		operand.exponent = '0;
		answer.ready     = 1'b0;

		// Directed: zero exponent (zero base too), inverse of zero, extreme bases,
		// extreme exponents, sign wrap, exponent ignored in inverse mode.
		add_item(1'b0, 64'sd0, '0);
		add_item(1'b0, 64'sd0, 63'd1);
		add_item(1'b1, 64'sd0, '0);
		add_item(1'b1, -longint'(PRIME_U), '1);
		add_item(1'b0, longint'(PRIME_U), 63'd5);
		add_item(1'b0, 64'sh7fff_ffff_ffff_ffff, '1);
		add_item(1'b0, 64'sh8000_0000_0000_0000, '0);
		add_item(1'b0, 64'sh8000_0000_0000_0000, 63'h5555_5555_5555_5555);
		add_item(1'b1, 64'sh8000_0000_0000_0000, '0);
		add_item(1'b1, 64'sh7fff_ffff_ffff_ffff, '1);
		add_item(1'b0, -64'sd1, 63'd2);
		add_item(1'b0, -64'sd1, 63'd3);
		add_item(1'b0, longint'(PRIME_U) - 1, 63'd1);
		add_item(1'b0, longint'(PRIME_U) + 1, 63'h2aaa_aaaa_aaaa_aaaa);
		add_item(1'b0, -longint'(PRIME_U) + 1, 63'd7);
		add_item(1'b1, 64'sd1, '0);
		add_item(1'b1, 64'sd2, 63'd12345);
		add_item(1'b1, 64'sd3, '0);
		add_item(1'b1, -64'sd2, '0);
		add_item(1'b0, 64'sd3, 63'h4000_0000_0000_0000);
		add_item(1'b0, 64'sd3, 63'd1);
		add_item(1'b0, 64'sd12345, '1);

		for (int n = 0; n < RANDOM_ITEMS; n++)
			pending_operands.push_back(random_operand());
		total_items = pending_operands.size();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_operands.size() == 0 && !operand.valid);
		wait (expected_results.size() == 0);
		// Let any stray result show up before deciding.
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && expected_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
